// File: rtl/fast_atan2_approximation_macros.svh
// Assertion helpers shared by the checker.
`ifndef FAST_ATAN2_APPROXIMATION_MACROS_SVH
`define FAST_ATAN2_APPROXIMATION_MACROS_SVH

// Check a property only outside reset.
`define FAT2_ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fat2 check failed");

// Check a property at every edge, reset included.
`define FAT2_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fat2 check failed");

`endif

// File: rtl/fat2_pkg.sv
package fat2_pkg;

    localparam int DataW     = 16;
    localparam int DenW      = 17;
    localparam int QW        = 16;
    localparam int DivStages = 16;
    localparam int PmagW     = 14;
    localparam int SumW      = 17;

    localparam logic [DataW-1:0] CubicReset  = 16'd6433;
    localparam logic [DataW-1:0] LinearReset = 16'd32169;

    localparam logic signed [SumW-1:0] PiQuarter      = 17'sd6434;
    localparam logic signed [SumW-1:0] PiThreeQuarter = 17'sd19302;
    localparam logic signed [SumW-1:0] PiFull         = 17'sd25736;

    typedef enum logic {
        CFG_CUBIC  = 1'b0,
        CFG_LINEAR = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] y_value;
        logic signed [DataW-1:0] x_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DataW-1:0] angle;
        logic                    undefined;
    } t_out_beat;

    // Per-item flags that ride along the pipeline.
    typedef struct packed {
        logic undef;
        logic y_neg;
        logic base_hi;
        logic r_neg;
    } t_side;

endpackage

// File: rtl/fat2_div.sv
module fat2_div import fat2_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [DenW-1:0] i_mag,
    input  logic [DenW-1:0] i_den,
    input  t_side           i_side,
    output logic            o_vld,
    output logic [QW-1:0]   o_q,
    output t_side           o_side
);

    // One quotient bit per stage, most significant first.
    logic            r_vld  [DivStages];
    logic [QW-1:0]   r_rem  [DivStages];
    logic [DenW-1:0] r_den  [DivStages];
    logic [QW-1:0]   r_q    [DivStages];
    t_side           r_side [DivStages];

    logic [DenW-1:0] p_rem  [DivStages];
    logic [DenW-1:0] p_den  [DivStages];
    logic [QW-1:0]   p_q    [DivStages];
    t_side           p_side [DivStages];
    logic            w_ge   [DivStages];
    logic [DenW-1:0] w_diff [DivStages];
    logic [QW-1:0]   n_rem  [DivStages];
    logic [QW-1:0]   n_q    [DivStages];

    always_comb begin
        for (int k = 0; k < DivStages; k++) begin
            if (k == 0) begin
                p_rem[k]  = i_mag;
                p_den[k]  = i_den;
                p_q[k]    = '0;
                p_side[k] = i_side;
            end else begin
                p_rem[k]  = {r_rem[k-1], 1'b0};
                p_den[k]  = r_den[k-1];
                p_q[k]    = r_q[k-1];
                p_side[k] = r_side[k-1];
            end
            w_ge[k]   = p_rem[k] >= p_den[k];
            w_diff[k] = p_rem[k] - p_den[k];
            // remainder stays below the divisor, so 16 bits hold it
            n_rem[k]  = w_ge[k] ? w_diff[k][QW-1:0] : p_rem[k][QW-1:0];
            n_q[k]    = p_q[k];
            n_q[k][QW-1-k] = w_ge[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivStages; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DivStages; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DivStages; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= p_den[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_vld  = r_vld[DivStages-1];
    assign o_q    = r_q[DivStages-1];
    assign o_side = r_side[DivStages-1];

endmodule

// File: rtl/fat2_poly.sv
module fat2_poly import fat2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [QW-1:0]    i_q,
    input  t_side            i_side,
    input  logic [DataW-1:0] i_cubic,
    input  logic [DataW-1:0] i_linear,
    output logic             o_vld,
    output logic [PmagW-1:0] o_pmag,
    output logic             o_pneg,
    output t_side            o_side
);

    logic [2*QW-1:0] w_qq;
    logic [2*QW-1:0] w_at;
    logic signed [QW:0] w_d;
    logic [QW:0]     w_dabs;
    logic [2*QW-1:0] w_m;

    logic             r1_vld, r2_vld, r3_vld, r4_vld;
    logic [QW-1:0]    r1_r2, r1_q;
    logic [QW-1:0]    r2_t, r2_q;
    logic [QW-1:0]    r3_dmag, r3_q;
    logic             r3_pneg, r4_pneg;
    logic [PmagW-1:0] r4_pmag;
    t_side            r1_side, r2_side, r3_side, r4_side;

    assign w_qq   = (2*QW)'(i_q) * (2*QW)'(i_q);
    assign w_at   = (2*QW)'(i_cubic) * (2*QW)'(r1_r2);
    assign w_d    = $signed({1'b0, r2_t}) - $signed({1'b0, i_linear});
    assign w_dabs = w_d[QW] ? (QW+1)'(0) - w_d : w_d;
    assign w_m    = (2*QW)'(r3_dmag) * (2*QW)'(r3_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // r squared, Q1.15
            r1_r2   <= w_qq[2*QW-2:QW-1];
            r1_q    <= i_q;
            r1_side <= i_side;
            // A times r squared, Q1.15
            r2_t    <= w_at[2*QW-2:QW-1];
            r2_q    <= r1_q;
            r2_side <= r1_side;
            // subtract B, split into sign and magnitude
            r3_dmag <= w_dabs[QW-1:0];
            r3_pneg <= w_d[QW] ^ r2_side.r_neg;
            r3_q    <= r2_q;
            r3_side <= r2_side;
            // scale the product down to a Q1.13 magnitude, truncated toward zero
            r4_pmag <= w_m[2*QW-2:2*QW-1-PmagW];
            r4_pneg <= r3_pneg;
            r4_side <= r3_side;
        end
    end

    assign o_vld  = r4_vld;
    assign o_pmag = r4_pmag;
    assign o_pneg = r4_pneg;
    assign o_side = r4_side;

endmodule

// File: rtl/fast_atan2_approximation.sv
// Pipeline: an accepted input beat passes 1 front stage, 16 divider stages,
//   4 polynomial stages and 1 output register on its way to the output beat.
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place.
// Reset: synchronous, active low; clears all valid bits and loads the coefficient
//   registers with their defaults (A = 6433, B = 32169).
module fast_atan2_approximation import fat2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [DataW-1:0] i_cfg_data
);

    // Pipeline advance: the output register is free or drains this cycle.
    logic w_en;

    // Coefficients
    logic [DataW-1:0] r_cubic;
    logic [DataW-1:0] r_linear;

    // Front stage: ratio numerator and denominator
    logic signed [DenW:0] w_y, w_x, w_ay, w_num, w_den, w_mag;
    t_side                w_side;
    logic                 r_f_vld;
    logic [DenW-1:0]      r_f_mag;
    logic [DenW-1:0]      r_f_den;
    t_side                r_f_side;

    // Divider and polynomial outputs
    logic                 w_div_vld;
    logic [QW-1:0]        w_div_q;
    t_side                w_div_side;
    logic                 w_poly_vld;
    logic [PmagW-1:0]     w_pmag;
    logic                 w_pneg;
    t_side                w_poly_side;

    // Final stage
    logic signed [SumW-1:0] w_p, w_base, w_sum, w_clip, w_ang;
    t_out_beat              n_out;
    logic                   r_out_valid;
    t_out_beat              r_out;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Write a coefficient; an index with no register behind it cannot occur.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cubic  <= CubicReset;
            r_linear <= LinearReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CUBIC:  r_cubic  <= i_cfg_data;
                CFG_LINEAR: r_linear <= i_cfg_data;
            endcase
        end
    end

    // Fold the vector into the first or second quadrant by |y|, then form
    // r = num / den with |num| <= den. x >= 0 takes base pi/4, else 3pi/4.
    always_comb begin
        w_y  = (DenW+1)'(i_in_data.y_value);
        w_x  = (DenW+1)'(i_in_data.x_value);
        w_ay = w_y[DenW] ? -w_y : w_y;
        if (!w_x[DenW]) begin
            w_num = w_x - w_ay;
            w_den = w_x + w_ay;
        end else begin
            w_num = w_x + w_ay;
            w_den = w_ay - w_x;
        end
        w_mag          = w_num[DenW] ? -w_num : w_num;
        w_side.undef   = (i_in_data.y_value == '0) && (i_in_data.x_value == '0);
        w_side.y_neg   = i_in_data.y_value[DataW-1];
        w_side.base_hi = i_in_data.x_value[DataW-1];
        w_side.r_neg   = w_num[DenW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_mag  <= w_mag[DenW-1:0];
            r_f_den  <= w_den[DenW-1:0];
            r_f_side <= w_side;
        end
    end

    // Restoring divider: 16 compare-subtract stages give the Q1.15 magnitude of r.
    fat2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_f_vld),
        .i_mag   (r_f_mag),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_vld   (w_div_vld),
        .o_q     (w_div_q),
        .o_side  (w_div_side)
    );

    // Cubic term (A*r*r - B)*r as sign and magnitude, a multiplier in every stage but the subtract.
    fat2_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_div_vld),
        .i_q      (w_div_q),
        .i_side   (w_div_side),
        .i_cubic  (r_cubic),
        .i_linear (r_linear),
        .o_vld    (w_poly_vld),
        .o_pmag   (w_pmag),
        .o_pneg   (w_pneg),
        .o_side   (w_poly_side)
    );

    // Add the base, saturate to plus or minus pi, mirror for negative y.
    // Both inputs zero: drop the angle to 0 and flag it.
    always_comb begin
        w_p    = w_pneg ? -$signed(SumW'(w_pmag)) : $signed(SumW'(w_pmag));
        w_base = w_poly_side.base_hi ? PiThreeQuarter : PiQuarter;
        w_sum  = w_base + w_p;
        if (w_sum > PiFull) begin
            w_clip = PiFull;
        end else if (w_sum < -PiFull) begin
            w_clip = -PiFull;
        end else begin
            w_clip = w_sum;
        end
        w_ang = w_poly_side.y_neg ? -w_clip : w_clip;
        if (w_poly_side.undef) begin
            n_out.angle     = '0;
            n_out.undefined = 1'b1;
        end else begin
            n_out.angle     = w_ang[DataW-1:0];
            n_out.undefined = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_poly_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/fat2_checker.sv
`include "fast_atan2_approximation_macros.svh"

module fat2_checker import fat2_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // A stalled output beat holds.
    `FAT2_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // Zero vector gives angle zero.
    `FAT2_ASSERT_RUN(a_undef_zero, i_clk, i_rst_n, o_out_valid && o_out_data.undefined |-> o_out_data.angle == '0)

    // Angle stays within plus or minus pi.
    `FAT2_ASSERT_RUN(a_angle_range, i_clk, i_rst_n, o_out_valid |-> ($signed(o_out_data.angle) <= 16'sd25736) && ($signed(o_out_data.angle) >= -16'sd25736))

    // An empty output register always takes a new beat.
    `FAT2_ASSERT_RUN(a_ready_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // Reset empties the output.
    `FAT2_ASSERT_ALL(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind fast_atan2_approximation fat2_checker u_fat2_checker (.*);

// File: verif/fat2_angle_checker.sv
`timescale 1ns / 1ps

// Watch both channels and the coefficient port, predict each angle from the
// coefficients in force at the time the input beat is accepted, and compare
// every output beat against the oldest prediction.
module fat2_angle_checker import fat2_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_beat         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_beat        i_out_data,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [DataW-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int ReportMax = 10;

    logic [DataW-1:0] coef_cubic;
    logic [DataW-1:0] coef_linear;
    t_out_beat        angle_queue[$];

    // Cubic atan2 in Q3.13 with truncating fixed-point steps.
    function automatic t_out_beat cubic_atan2(input t_in_beat pair,
                                              input logic [DataW-1:0] ca_in,
                                              input logic [DataW-1:0] cb_in);
        longint    yv, xv, ay, num, den, base, q, r, r2, t, d, prod, p, ang;
        longint    ca, cb, pi_lim;
        t_out_beat res;
        yv = pair.y_value;
        xv = pair.x_value;
        ca = ca_in;
        cb = cb_in;
        pi_lim = PiFull;
        res.angle = '0;
        res.undefined = 1'b0;
        if (yv == 0 && xv == 0) begin
            res.undefined = 1'b1;
            return res;
        end
        ay = (yv < 0) ? -yv : yv;
        if (xv >= 0) begin
            num = xv - ay;
            den = xv + ay;
            base = PiQuarter;
        end else begin
            num = xv + ay;
            den = ay - xv;
            base = PiThreeQuarter;
        end
        q = ((num < 0 ? -num : num) << 15) / den;
        r = (num < 0) ? -q : q;
        r2 = (r * r) >> 15;
        t = (ca * r2) >> 15;
        d = t - cb;
        prod = d * r;
        p = (prod < 0) ? -((-prod) >> 17) : (prod >> 17);
        ang = base + p;
        if (ang > pi_lim) begin
            ang = pi_lim;
        end else if (ang < -pi_lim) begin
            ang = -pi_lim;
        end
        if (yv < 0) begin
            ang = -ang;
        end
        res.angle = ang[DataW-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            coef_cubic = CubicReset;
            coef_linear = LinearReset;
            angle_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CUBIC: begin
                        coef_cubic = i_cfg_data;
                    end
                    CFG_LINEAR: begin
                        coef_linear = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                angle_queue.push_back(cubic_atan2(i_in_data, coef_cubic, coef_linear));
            end
            if (i_out_valid && i_out_ready) begin
                if (angle_queue.size() == 0) begin
                    if (o_fail_count < ReportMax) begin
                        $display("unexpected beat: angle %0d undefined %0b",
                                 i_out_data.angle, i_out_data.undefined);
                    end
                    o_fail_count++;
                end else begin
                    want = angle_queue.pop_front();
                    if (want.angle !== i_out_data.angle ||
                        want.undefined !== i_out_data.undefined) begin
                        if (o_fail_count < ReportMax) begin
                            $display("mismatch: angle exp %0d got %0d, undefined exp %0b got %0b",
                                     want.angle, i_out_data.angle,
                                     want.undefined, i_out_data.undefined);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = angle_queue.size();
    end

endmodule

// File: verif/fast_atan2_approximation_tb.sv
`timescale 1ns / 1ps

module fast_atan2_approximation_tb;
    import fat2_pkg::*;

    localparam int PhaseCount   = 7;
    localparam int PhaseBeats   = 243;
    localparam int DirectCount  = 22;
    localparam int DrainCycles  = 30;     // pipeline latency plus margin
    localparam int StallLimit   = 5000;   // cycles with no beat on either channel

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_beat         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_beat        o_out_data;
    logic             i_cfg_we = 1'b0;
    t_cfg_idx         i_cfg_idx = CFG_CUBIC;
    logic [DataW-1:0] i_cfg_data = '0;

    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    logic gaps_on = 1'b1;

    // Corner pairs: zero vector, axes, diagonals, full-scale extremes and
    // near-axis vectors where the ratio comes near plus or minus one.
    logic signed [DataW-1:0] corner_y [DirectCount] = '{
        16'sd0, 16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd32767, -16'sd32768,
        -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0,
        16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd100, -16'sd32768, 16'sd5,
        -16'sd21846, 16'sd1
    };
    logic signed [DataW-1:0] corner_x [DirectCount] = '{
        16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd32767, -16'sd32768,
        16'sd32767, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767,
        16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd32768, -16'sd1, 16'sd32767,
        -16'sd21845, -16'sd32768
    };

    // Coefficient settings per phase; random phases are filled in at run time.
    logic [DataW-1:0] phase_cubic  [PhaseCount] = '{
        CubicReset, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, CubicReset
    };
    logic [DataW-1:0] phase_linear [PhaseCount] = '{
        LinearReset, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, LinearReset
    };

    fast_atan2_approximation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fat2_angle_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: drop ready about a third of the time unless gaps are off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Pick one vector component: full-range values, half of them scaled down by a
    // random shift so that every ratio between the two components shows up,
    // with a share of extremes and tiny values.
    function automatic logic signed [DataW-1:0] pick_component();
        int unsigned             sel;
        logic signed [DataW-1:0] raw;
        sel = $urandom_range(99);
        raw = DataW'($urandom);
        if (sel < 10) begin
            case ($urandom_range(4))
                0: return 16'sd0;
                1: return 16'sd1;
                2: return -16'sd1;
                3: return 16'sd32767;
                default: return -16'sd32768;
            endcase
        end else if (sel < 20) begin
            return DataW'($signed($urandom_range(8)) - 4);
        end else if (sel < 60) begin
            return raw >>> $urandom_range(DataW - 1);
        end
        return raw;
    endfunction

    // Present one (y, x) beat and hold it until the block takes it. Idle
    // cycles go in front of the beat; valid is not lowered until the beat is taken.
    task automatic send_pair(input logic signed [DataW-1:0] y,
                             input logic signed [DataW-1:0] x);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{y_value: y, x_value: x};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every predicted angle has come back.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_coef(input t_cfg_idx idx, input logic [DataW-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        // Hold reset, then release it once.
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0 runs on reset coefficients, corner vectors first.
        for (int i = 0; i < DirectCount; i++) begin
            send_pair(corner_y[i], corner_x[i]);
        end

        for (int ph = 0; ph < PhaseCount; ph++) begin
            if (ph != 0) begin
                // Change coefficients only with the pipeline empty.
                drain_pipe();
                if (ph == 5 || ph == 6) begin
                    phase_cubic[ph] = DataW'($urandom_range(65535));
                    phase_linear[ph] = DataW'($urandom_range(65535));
                end
                write_coef(CFG_CUBIC, phase_cubic[ph]);
                write_coef(CFG_LINEAR, phase_linear[ph]);
            end
            // Run one phase; phase 2 alone runs back to back on both sides.
            gaps_on = (ph != 2);
            for (int n = 0; n < PhaseBeats; n++) begin
                send_pair(pick_component(), pick_component());
            end
        end

        drain_pipe();
        repeat (DrainCycles) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/fat2_pkg.sv
rtl/fat2_div.sv
rtl/fat2_poly.sv
rtl/fast_atan2_approximation.sv
rtl/fat2_checker.sv
verif/fat2_angle_checker.sv
verif/fast_atan2_approximation_tb.sv
